// ===== rtl/aar_pkg.sv =====
`default_nettype none
package aar_pkg;

  localparam int AtanEntries = 24;
  localparam int CordicW = 34;
  localparam int AngleW = 32;

  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [63:0] OneQ28 = 64'sd268435456;
  localparam logic signed [CordicW:0] OneQ30 = 35'sd1073741824;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [AngleW-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [1:0]         q;
  } side_t;

  typedef struct packed {
    logic signed [15:0] r0c0;
    logic signed [15:0] r0c1;
    logic signed [15:0] r0c2;
    logic signed [15:0] r1c0;
    logic signed [15:0] r1c1;
    logic signed [15:0] r1c2;
    logic signed [15:0] r2c0;
    logic signed [15:0] r2c1;
    logic signed [15:0] r2c2;
  } matrix_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [AngleW-1:0] atan_turns(input int i);
    case (i)
      0:  atan_turns = 32'sh20000000;
      1:  atan_turns = 32'sh12E4051E;
      2:  atan_turns = 32'sh09FB385B;
      3:  atan_turns = 32'sh051111D4;
      4:  atan_turns = 32'sh028B0D43;
      5:  atan_turns = 32'sh0145D7E1;
      6:  atan_turns = 32'sh00A2F61E;
      7:  atan_turns = 32'sh00517C55;
      8:  atan_turns = 32'sh0028BE53;
      9:  atan_turns = 32'sh00145F2F;
      10: atan_turns = 32'sh000A2F98;
      11: atan_turns = 32'sh000517CC;
      12: atan_turns = 32'sh00028BE6;
      13: atan_turns = 32'sh000145F3;
      14: atan_turns = 32'sh0000A2FA;
      15: atan_turns = 32'sh0000517D;
      16: atan_turns = 32'sh000028BE;
      17: atan_turns = 32'sh0000145F;
      18: atan_turns = 32'sh00000A30;
      19: atan_turns = 32'sh00000518;
      20: atan_turns = 32'sh0000028C;
      21: atan_turns = 32'sh00000146;
      22: atan_turns = 32'sh000000A3;
      23: atan_turns = 32'sh00000051;
      default: atan_turns = 32'sh0;
    endcase
  endfunction

  // round a 2^58 scaled value to Q2.14 and saturate
  function automatic logic signed [15:0] to_q14(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [19:0] r;
    t = v + 64'sd8796093022208;
    r = t[63:44];
    if (r > 20'sd32767) begin
      to_q14 = 16'sh7FFF;
    end else if (r < -20'sd32768) begin
      to_q14 = 16'sh8000;
    end else begin
      to_q14 = r[15:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aar_axis_if.sv =====
`default_nettype none
interface aar_axis_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic signed [15:0] angle;
  modport source (output valid, axis_x, axis_y, axis_z, angle, input ready);
  modport sink (input valid, axis_x, axis_y, axis_z, angle, output ready);
endinterface
`default_nettype wire

// ===== rtl/aar_mat_if.sv =====
`default_nettype none
interface aar_mat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rot_r0c0;
  logic signed [15:0] rot_r0c1;
  logic signed [15:0] rot_r0c2;
  logic signed [15:0] rot_r1c0;
  logic signed [15:0] rot_r1c1;
  logic signed [15:0] rot_r1c2;
  logic signed [15:0] rot_r2c0;
  logic signed [15:0] rot_r2c1;
  logic signed [15:0] rot_r2c2;
  modport source (output valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                  rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, input ready);
  modport sink (input valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, output ready);
endinterface
`default_nettype wire

// ===== rtl/aar_cordic_stage.sv =====
`default_nettype none
module aar_cordic_stage #(
  parameter int STEP = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            v_in,
  input  wire aar_pkg::cordic_t c_in,
  input  wire aar_pkg::side_t   s_in,
  output logic                 v_out,
  output aar_pkg::cordic_t     c_out,
  output aar_pkg::side_t       s_out
);
  import aar_pkg::*;

  cordic_t c_next;
  logic signed [CordicW-1:0] dx;
  logic signed [CordicW-1:0] dy;

  // rotate one micro-step towards zero residual
  always_comb begin
    dx = c_in.y >>> STEP;
    dy = c_in.x >>> STEP;
    if (c_in.z >= 0) begin
      c_next.x = c_in.x - dx;
      c_next.y = c_in.y + dy;
      c_next.z = c_in.z - atan_turns(STEP);
    end else begin
      c_next.x = c_in.x + dx;
      c_next.y = c_in.y - dy;
      c_next.z = c_in.z + atan_turns(STEP);
    end
  end

  // advance on enable
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_out <= c_next;
      s_out <= s_in;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/aar_matrix.sv =====
`default_nettype none
module aar_matrix (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            v_in,
  input  wire aar_pkg::cordic_t c_in,
  input  wire aar_pkg::side_t   s_in,
  output logic                 v_out,
  output aar_pkg::matrix_t     m_out
);
  import aar_pkg::*;

  // stage A: quadrant fold
  logic va;
  logic signed [CordicW-1:0] c_a, s_a;
  logic signed [CordicW:0]   omc_a;
  logic signed [15:0] x_a, y_a, z_a;
  logic signed [CordicW-1:0] c_fold, s_fold;

  always_comb begin
    case (s_in.q)
      2'd0: begin c_fold = c_in.x;  s_fold = c_in.y;  end
      2'd1: begin c_fold = -c_in.y; s_fold = c_in.x;  end
      2'd2: begin c_fold = -c_in.x; s_fold = -c_in.y; end
      default: begin c_fold = c_in.y; s_fold = -c_in.x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_a   <= c_fold;
      s_a   <= s_fold;
      omc_a <= OneQ30 - {c_fold[CordicW-1], c_fold};
      x_a   <= s_in.ax;
      y_a   <= s_in.ay;
      z_a   <= s_in.az;
    end
  end

  // stage B: axis products and axis-times-sine
  logic vb;
  logic signed [31:0] xx_b, yy_b, zz_b, xy_b, xz_b, yz_b;
  logic signed [49:0] xs_b, ys_b, zs_b;
  logic signed [CordicW-1:0] c_b;
  logic signed [CordicW:0]   omc_b;

  always_ff @(posedge clk) begin
    if (en) begin
      xx_b  <= x_a * x_a;
      yy_b  <= y_a * y_a;
      zz_b  <= z_a * z_a;
      xy_b  <= x_a * y_a;
      xz_b  <= x_a * z_a;
      yz_b  <= y_a * z_a;
      xs_b  <= x_a * s_a;
      ys_b  <= y_a * s_a;
      zs_b  <= z_a * s_a;
      c_b   <= c_a;
      omc_b <= omc_a;
    end
  end

  // stage C: cosine terms, with the squares and sine products rescaled
  logic vc;
  logic signed [63:0] xx_c, yy_c, zz_c;
  logic signed [63:0] dx_c, dy_c, dz_c;
  logic signed [63:0] lxy_c, lxz_c, lyz_c;
  logic signed [63:0] rx_c, ry_c, rz_c;
  logic signed [32:0] sx_b, sy_b, sz_b;
  logic signed [66:0] dxp, dyp, dzp, lxyp, lxzp, lyzp;

  always_comb begin
    sx_b = 33'(OneQ28) - {xx_b[31], xx_b};
    sy_b = 33'(OneQ28) - {yy_b[31], yy_b};
    sz_b = 33'(OneQ28) - {zz_b[31], zz_b};
    dxp  = sx_b * c_b;
    dyp  = sy_b * c_b;
    dzp  = sz_b * c_b;
    lxyp = xy_b * omc_b;
    lxzp = xz_b * omc_b;
    lyzp = yz_b * omc_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_c  <= 64'(xx_b) <<< 30;
      yy_c  <= 64'(yy_b) <<< 30;
      zz_c  <= 64'(zz_b) <<< 30;
      dx_c  <= dxp[63:0];
      dy_c  <= dyp[63:0];
      dz_c  <= dzp[63:0];
      lxy_c <= lxyp[63:0];
      lxz_c <= lxzp[63:0];
      lyz_c <= lyzp[63:0];
      rx_c  <= 64'(xs_b) <<< 14;
      ry_c  <= 64'(ys_b) <<< 14;
      rz_c  <= 64'(zs_b) <<< 14;
    end
  end

  // stage D: sum, round and saturate into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_out.r0c0 <= to_q14(xx_c + dx_c);
      m_out.r0c1 <= to_q14(lxy_c - rz_c);
      m_out.r0c2 <= to_q14(lxz_c + ry_c);
      m_out.r1c0 <= to_q14(lxy_c + rz_c);
      m_out.r1c1 <= to_q14(yy_c + dy_c);
      m_out.r1c2 <= to_q14(lyz_c - rx_c);
      m_out.r2c0 <= to_q14(lxz_c - ry_c);
      m_out.r2c1 <= to_q14(lyz_c + rx_c);
      m_out.r2c2 <= to_q14(zz_c + dz_c);
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      vc    <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      va    <= v_in;
      vb    <= va;
      vc    <= vb;
      v_out <= vc;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/axis_angle_rotation_matrix.sv =====
`default_nettype none
// Axis-angle to 3x3 rotation matrix. Takes an axis (Q2.14) and a binary angle
// (full turn = 65536) and returns the nine Rodrigues entries in Q2.14, rounded
// and saturated; the axis is used as given, without normalisation. One item is
// accepted every cycle while no result waits for its transfer. The pipe registers,
// in order, are: quadrant reduction, the CORDIC steps, quadrant fold, the
// product multipliers and rounding into the output register. The whole pipe
// advances together and holds while a result waits for its transfer.
module axis_angle_rotation_matrix #(
  parameter int SINCOS_STAGES = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  aar_axis_if.sink   axis,
  aar_mat_if.source  matrix
);
  import aar_pkg::*;

  localparam int Steps = (SINCOS_STAGES < AtanEntries) ? SINCOS_STAGES : AtanEntries;

  logic    en;
  logic    v   [0:Steps];
  cordic_t cd  [0:Steps];
  side_t   sd  [0:Steps];
  logic    mv;
  matrix_t mat;
  logic [1:0]  q_in;
  logic [15:0] r_in;

  assign en = !mv || matrix.ready;
  assign axis.ready = en;

  // split the angle into quadrant and residual
  always_comb begin
    q_in = axis.angle[15:14] + {1'b0, axis.angle[13]};
    r_in = axis.angle - {q_in, 14'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= axis.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd[0].x <= CordicGain;
      cd[0].y <= '0;
      cd[0].z <= {r_in, 16'd0};
      sd[0].ax <= axis.axis_x;
      sd[0].ay <= axis.axis_y;
      sd[0].az <= axis.axis_z;
      sd[0].q  <= q_in;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    aar_cordic_stage #(.STEP(i)) u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_in  (v[i]),
      .c_in  (cd[i]),
      .s_in  (sd[i]),
      .v_out (v[i+1]),
      .c_out (cd[i+1]),
      .s_out (sd[i+1])
    );
  end

  aar_matrix u_matrix (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .v_in  (v[Steps]),
    .c_in  (cd[Steps]),
    .s_in  (sd[Steps]),
    .v_out (mv),
    .m_out (mat)
  );

  assign matrix.valid    = mv;
  assign matrix.rot_r0c0 = mat.r0c0;
  assign matrix.rot_r0c1 = mat.r0c1;
  assign matrix.rot_r0c2 = mat.r0c2;
  assign matrix.rot_r1c0 = mat.r1c0;
  assign matrix.rot_r1c1 = mat.r1c1;
  assign matrix.rot_r1c2 = mat.r1c2;
  assign matrix.rot_r2c0 = mat.r2c0;
  assign matrix.rot_r2c1 = mat.r2c1;
  assign matrix.rot_r2c2 = mat.r2c2;

  // input held back only by a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !axis.ready |-> (matrix.valid && !matrix.ready))
    else $error("input stalled without a waiting result");

  // a stalled pipe keeps its head item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (matrix.valid && !matrix.ready) |=> (matrix.valid && $stable(mat)))
    else $error("result changed while waiting for transfer");

  // a stalled pipe does not lose an item held in the CORDIC front stage
  a_front: assert property (@(posedge clk) disable iff (rst)
    (!en && v[0]) |=> v[0])
    else $error("front stage item dropped during stall");
endmodule
`default_nettype wire

// ===== tb/sv/aar_checker.sv =====
`default_nettype none
module aar_checker #(
  parameter int SINCOS_STAGES = 16
) (
  input wire logic clk,
  input wire logic rst,
  aar_axis_if      axis,
  aar_mat_if       matrix,
  output int       fail_count,
  output int       pending_count
);
  import aar_pkg::*;

  matrix_t expected_matrices[$];

  function automatic logic signed [63:0] asr(input logic signed [63:0] v, input int s);
    asr = v >>> s;
  endfunction

  function automatic logic signed [15:0] round_sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< 43)) >>> 44;
    if (r > 64'sd32767) round_sat = 16'sh7FFF;
    else if (r < -64'sd32768) round_sat = 16'sh8000;
    else round_sat = r[15:0];
  endfunction

  function automatic logic signed [63:0] rot_step(input int i);
    logic signed [63:0] tab [24];
    tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
    rot_step = tab[i];
  endfunction

  // compute the rotation matrix for one axis and angle
  function automatic matrix_t rotation_of(input logic signed [15:0] ax, ay, az, ang);
    logic [15:0] u;
    logic [1:0] q;
    logic signed [63:0] r, zr, xc, yc, dx, dy, c, s, omc, x, y, z, d, n;
    matrix_t m;
    u = ang;
    q = 2'((u + 16'h2000) >> 14);
    r = 64'($signed(16'(u - {q, 14'b0})));
    zr = r * 65536;
    xc = 64'sd652032874;
    yc = 0;
    for (int i = 0; i < SINCOS_STAGES && i < 24; i++) begin
      dx = asr(yc, i);
      dy = asr(xc, i);
      if (zr >= 0) begin
        xc -= dx; yc += dy; zr -= rot_step(i);
      end else begin
        xc += dx; yc -= dy; zr += rot_step(i);
      end
    end
    case (q)
      2'd0: begin c = xc; s = yc; end
      2'd1: begin c = -yc; s = xc; end
      2'd2: begin c = -xc; s = -yc; end
      default: begin c = yc; s = -xc; end
    endcase
    omc = (64'sd1 <<< 30) - c;
    x = ax; y = ay; z = az;
    d = (64'sd1 <<< 28);
    n = 64'sd16384;
    m.r0c0 = round_sat(x * x * (64'sd1 <<< 30) + (d - x * x) * c);
    m.r0c1 = round_sat(y * x * omc - z * s * n);
    m.r0c2 = round_sat(x * z * omc + y * s * n);
    m.r1c0 = round_sat(y * x * omc + z * s * n);
    m.r1c1 = round_sat(y * y * (64'sd1 <<< 30) + (d - y * y) * c);
    m.r1c2 = round_sat(y * z * omc - x * s * n);
    m.r2c0 = round_sat(x * z * omc - y * s * n);
    m.r2c1 = round_sat(y * z * omc + x * s * n);
    m.r2c2 = round_sat(z * z * (64'sd1 <<< 30) + (d - z * z) * c);
    return m;
  endfunction

  // predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    matrix_t got, want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (axis.valid && axis.ready)
        expected_matrices.push_back(rotation_of(axis.axis_x, axis.axis_y,
                                                axis.axis_z, axis.angle));
      if (matrix.valid && matrix.ready) begin
        got = '{matrix.rot_r0c0, matrix.rot_r0c1, matrix.rot_r0c2,
                matrix.rot_r1c0, matrix.rot_r1c1, matrix.rot_r1c2,
                matrix.rot_r2c0, matrix.rot_r2c1, matrix.rot_r2c2};
        if (expected_matrices.size() == 0) begin
          $display("%0t: unexpected matrix %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_matrices.pop_front();
          if (got !== want) begin
            $display("%0t: matrix mismatch expected %h actual %h", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count = expected_matrices.size();
  end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
  localparam int Stages = 16;
  localparam int RandomItems = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;
  bit   quiet_phase = 1'b0;
  bit   hold_off = 1'b0;

  aar_axis_if axis ();
  aar_mat_if  matrix ();

  axis_angle_rotation_matrix #(.SINCOS_STAGES(Stages)) i_dut (
    .clk(clk), .rst(rst), .axis(axis), .matrix(matrix)
  );

  aar_checker #(.SINCOS_STAGES(Stages)) i_checker (
    .clk(clk), .rst(rst), .axis(axis), .matrix(matrix),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always #4 clk = ~clk;

  // abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("axis_angle_rotation_matrix verification failed");
      $finish;
    end
  end

  // stall the receiver in bursts, with one long hold-off
  initial begin
    int n;
    bit held;
    held = 1'b0;
    matrix.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off && !held) begin
        matrix.ready <= 1'b0;
        repeat (200) @(negedge clk);
        held = 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 18);
        matrix.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        matrix.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // offer one item and hold it until transferred
  task automatic send_item(input logic [15:0] ax, ay, az, ang);
    int n;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 18);
      axis.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    axis.valid  <= 1'b1;
    axis.axis_x <= ax;
    axis.axis_y <= ay;
    axis.axis_z <= az;
    axis.angle  <= ang;
    @(posedge clk);
    while (!axis.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_component();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'h4000;
      2: return 16'hC000;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  initial begin
    logic [15:0] corners [8];
    corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h2000,
                16'hE000, 16'h1FFF};
    axis.valid = 1'b0;
    axis.axis_x = '0;
    axis.axis_y = '0;
    axis.axis_z = '0;
    axis.angle = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // field extremes, quadrant edges and unnormalised axes
    for (int i = 0; i < 8; i++)
      send_item(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8], corners[i]);
    send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000);
    send_item(16'h8000, 16'h8000, 16'h8000, 16'hC000);
    send_item(16'h4000, 16'h0000, 16'h0000, 16'h2000);
    send_item(16'h0000, 16'h4000, 16'h0000, 16'h6000);
    send_item(16'h0000, 16'h0000, 16'h4000, 16'hA000);
    send_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001);
    send_item(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);

    // random items, with a long receiver hold-off early on
    for (int i = 0; i < RandomItems; i++) begin
      if (i == 100) hold_off = 1'b1;
      if (i == RandomItems - 150) quiet_phase = 1'b1;
      send_item(pick_component(), pick_component(), pick_component(), 16'($urandom));
    end
    axis.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (Stages + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("axis_angle_rotation_matrix verification clean");
    end else begin
      $display("axis_angle_rotation_matrix verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/aar_pkg.sv
rtl/aar_axis_if.sv
rtl/aar_mat_if.sv
rtl/aar_cordic_stage.sv
rtl/aar_matrix.sv
rtl/axis_angle_rotation_matrix.sv
tb/sv/aar_checker.sv
tb/sv/testbench.sv
